/* design/mdr_pkg.sv */
package mdr_pkg;

    localparam int SIZE_W = 16;
    localparam int TYPE_W = 8;
    localparam int OFS_OUT_W = 16;
    localparam int STAT_W = 2;

    localparam int DEF_RING_DEPTH = 128;
    localparam int DEF_OFFSET_BITS = 16;

    localparam logic [SIZE_W-1:0] BUF_SIZE_RESET = 16'hFFFF;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_POP     = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0]
    {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_TOO_BIG = 2'd2,
        STAT_EMPTY   = 2'd3
    } status_t;

    typedef struct packed
    {
        status_t               status;
        logic [OFS_OUT_W-1:0]  assigned_offset;
        logic                  is_empty;
        logic                  is_full;
    } res_t;

endpackage

/* design/mdr_desc_mem.sv */
module mdr_desc_mem #(
    parameter int DEPTH = mdr_pkg::DEF_RING_DEPTH,
    parameter int DATA_W = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // A read of the entry being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/mdr_ctrl.sv */
module mdr_ctrl #(
    parameter int RING_DEPTH = mdr_pkg::DEF_RING_DEPTH,
    parameter int OFFSET_BITS = mdr_pkg::DEF_OFFSET_BITS,
    localparam int IDX_W = $clog2(RING_DEPTH),
    localparam int ENTRY_W = mdr_pkg::SIZE_W + mdr_pkg::TYPE_W + OFFSET_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  mdr_pkg::op_t               in_op,
    input  logic [mdr_pkg::SIZE_W-1:0] in_size,
    input  logic [mdr_pkg::TYPE_W-1:0] in_type,
    input  logic                       cfg_valid,
    input  logic [mdr_pkg::SIZE_W-1:0] cfg_data,
    input  logic                       out_free,
    output logic                       res_load,
    output mdr_pkg::res_t              res,
    output logic                       mem_we,
    output logic [IDX_W-1:0]           mem_waddr,
    output logic [ENTRY_W-1:0]         mem_wdata,
    output logic                       mem_re,
    output logic [IDX_W-1:0]           mem_raddr
);

    localparam int SUM_W = ((OFFSET_BITS > mdr_pkg::SIZE_W) ? OFFSET_BITS : mdr_pkg::SIZE_W) + 1;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOAD
    } state_t;

    state_t                     state_reg;
    logic [IDX_W-1:0]           front_reg;
    logic [IDX_W-1:0]           front_next;
    logic [IDX_W-1:0]           rear_reg;
    logic [IDX_W-1:0]           rear_next;
    logic [OFFSET_BITS-1:0]     next_offset_reg;
    logic [OFFSET_BITS-1:0]     next_offset_next;
    logic [mdr_pkg::SIZE_W-1:0] buffer_size_reg;
    mdr_pkg::res_t              res_reg;
    mdr_pkg::res_t              res_next;

    logic                       accept;
    logic [IDX_W-1:0]           rear_inc;
    logic [IDX_W-1:0]           front_inc;
    logic [SUM_W-1:0]           sum;
    logic                       wrap;
    logic [OFFSET_BITS-1:0]     ofs;
    logic                       do_write;
    logic                       do_pop;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        r = (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + IDX_W'(1);
        return r;
    endfunction

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        rear_inc  = wrap_inc(rear_reg);
        front_inc = wrap_inc(front_reg);
        sum  = SUM_W'(next_offset_reg) + SUM_W'(in_size);
        wrap = sum > SUM_W'(buffer_size_reg);
        ofs  = wrap ? '0 : next_offset_reg;

        do_write = 1'b0;
        do_pop   = 1'b0;
        res_next.status = mdr_pkg::STAT_OK;
        unique case (in_op)
            mdr_pkg::OP_ENQUEUE:
            begin
                if (rear_inc == front_reg)
                begin
                    res_next.status = mdr_pkg::STAT_FULL;
                end
                else if (in_size > buffer_size_reg)
                begin
                    res_next.status = mdr_pkg::STAT_TOO_BIG;
                end
                else
                begin
                    do_write = 1'b1;
                end
            end
            mdr_pkg::OP_POP:
            begin
                if (front_reg == rear_reg)
                begin
                    res_next.status = mdr_pkg::STAT_EMPTY;
                end
                else
                begin
                    do_pop = 1'b1;
                end
            end
            default:
            begin
                res_next.status = mdr_pkg::STAT_OK;
            end
        endcase

        front_next = do_pop ? front_inc : front_reg;
        rear_next  = do_write ? rear_inc : rear_reg;
        next_offset_next = wrap ? OFFSET_BITS'(in_size) : OFFSET_BITS'(sum);

        res_next.assigned_offset = do_write ? mdr_pkg::OFS_OUT_W'(ofs) : '0;
        res_next.is_empty = (front_next == rear_next);
        res_next.is_full  = (wrap_inc(rear_next) == front_next);
    end

    assign mem_we    = accept && do_write;
    assign mem_waddr = rear_reg;
    assign mem_wdata = {ofs, in_type, in_size};
    assign mem_re    = accept;
    assign mem_raddr = front_next;

    assign res_load = (state_reg == ST_LOAD) && out_free;
    assign res      = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            front_reg       <= '0;
            rear_reg        <= '0;
            next_offset_reg <= '0;
            buffer_size_reg <= mdr_pkg::BUF_SIZE_RESET;
            res_reg         <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                buffer_size_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        front_reg <= front_next;
                        rear_reg  <= rear_next;
                        if (do_write)
                        begin
                            next_offset_reg <= next_offset_next;
                        end
                        res_reg   <= res_next;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_reg.is_empty && res_reg.is_full))
        else $error("Ring reported as both full and empty.");

    a_accept_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOAD) && !in_ready)
        else $error("Item accepted without moving to the load state.");

    a_reject_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (res_reg.status != mdr_pkg::STAT_OK) |-> (res_reg.assigned_offset == '0))
        else $error("Rejected item was given an offset.");

    a_reject_keeps_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !do_write && !do_pop) |=> ($stable(front_reg) && $stable(rear_reg)))
        else $error("Rejected item moved a ring pointer.");

endmodule

/* design/message_descriptor_ring_core.sv */
// Channel | Direction | Handshake          | Payload
// s       | in        | s_tvalid/s_tready  | operation (tuser), message_size, message_type
// m       | out       | m_tvalid/m_tready  | status, offsets, flags, front descriptor
// cfg     | in        | cfg_valid/cfg_ready| buffer_size
//
// For each item the controller first decides, updates the pointers, writes the
// ring memory and starts the read of the new front slot; in its load state it
// then loads the registered memory read into the output register once free.
// Reset clears the pointers and the allocation offset and sets buffer_size to 65535;
// the ring memory is not cleared and needs no clearing pass.
// While a finished result waits in the output register the next item is still
// accepted; its result waits in the controller until the output register frees.
module message_descriptor_ring_core #(
    parameter int RING_DEPTH = mdr_pkg::DEF_RING_DEPTH,
    parameter int OFFSET_BITS = mdr_pkg::DEF_OFFSET_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // Bits from the lowest: message_size[15:0], message_type[23:16].
    input  logic [mdr_pkg::S_TDATA_W-1:0] s_tdata,
    // Bits from the lowest: operation[0].
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // Bits from the lowest: status[1:0], assigned_offset[17:2], is_empty[18],
    // is_full[19], front_size[35:20], front_type[43:36], front_offset[59:44], zero.
    output logic [mdr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mdr_pkg::SIZE_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int ENTRY_W = mdr_pkg::SIZE_W + mdr_pkg::TYPE_W + OFFSET_BITS;
    localparam int PAD_W = mdr_pkg::M_TDATA_W - mdr_pkg::STAT_W - mdr_pkg::OFS_OUT_W - 2
                           - mdr_pkg::SIZE_W - mdr_pkg::TYPE_W - mdr_pkg::OFS_OUT_W;

    logic                          out_free;
    logic                          res_load;
    mdr_pkg::res_t                 res;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    logic [ENTRY_W-1:0]            mem_wdata;
    logic                          mem_re;
    logic [IDX_W-1:0]              mem_raddr;
    logic [ENTRY_W-1:0]            mem_rdata;

    logic [mdr_pkg::SIZE_W-1:0]    front_size;
    logic [mdr_pkg::TYPE_W-1:0]    front_type;
    logic [mdr_pkg::OFS_OUT_W-1:0] front_offset;

    logic                          m_tvalid_reg;
    logic [mdr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic [mdr_pkg::M_TDATA_W-1:0] m_tdata_next;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    mdr_ctrl #(
        .RING_DEPTH  (RING_DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (mdr_pkg::op_t'(s_tuser[0])),
        .in_size   (s_tdata[mdr_pkg::SIZE_W-1:0]),
        .in_type   (s_tdata[mdr_pkg::SIZE_W +: mdr_pkg::TYPE_W]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr)
    );

    mdr_desc_mem #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // An empty ring shows an all-zero front descriptor.
    always_comb
    begin
        if (res.is_empty)
        begin
            front_size   = '0;
            front_type   = '0;
            front_offset = '0;
        end
        else
        begin
            front_size   = mem_rdata[mdr_pkg::SIZE_W-1:0];
            front_type   = mem_rdata[mdr_pkg::SIZE_W +: mdr_pkg::TYPE_W];
            front_offset = mdr_pkg::OFS_OUT_W'(
                mem_rdata[ENTRY_W-1:mdr_pkg::SIZE_W+mdr_pkg::TYPE_W]);
        end
        m_tdata_next = {{PAD_W{1'b0}}, front_offset, front_type, front_size,
                        res.is_full, res.is_empty, res.assigned_offset, res.status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (res_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= m_tdata_next;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 200;

    typedef struct
    {
        mdr_pkg::op_t               op;
        logic [mdr_pkg::SIZE_W-1:0] msg_len;
        logic [mdr_pkg::TYPE_W-1:0] msg_kind;
    } ring_req_t;

    typedef struct packed
    {
        logic [mdr_pkg::SIZE_W-1:0]    msg_len;
        logic [mdr_pkg::TYPE_W-1:0]    msg_kind;
        logic [mdr_pkg::OFS_OUT_W-1:0] msg_ofs;
    } slot_t;

    typedef struct
    {
        mdr_pkg::status_t              status;
        logic [mdr_pkg::OFS_OUT_W-1:0] assigned;
        logic                          empty;
        logic                          full;
        logic [mdr_pkg::SIZE_W-1:0]    f_len;
        logic [mdr_pkg::TYPE_W-1:0]    f_kind;
        logic [mdr_pkg::OFS_OUT_W-1:0] f_ofs;
    } ring_outcome_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mdr_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]                    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mdr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [mdr_pkg::SIZE_W-1:0]    cfg_data = '0;

    message_descriptor_ring_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    ring_req_t     pend_q[$];
    ring_outcome_t outcome_q[$];
    ring_req_t     cur_req;

    slot_t                         slots [mdr_pkg::DEF_RING_DEPTH];
    logic [6:0]                    head_idx = '0;
    logic [6:0]                    tail_idx = '0;
    logic [mdr_pkg::OFS_OUT_W-1:0] alloc_ptr = '0;
    logic [mdr_pkg::SIZE_W-1:0]    buf_bytes = mdr_pkg::BUF_SIZE_RESET;

    int  errors = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  hold_ask = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  quiet = 0;
    bit  calm = 1'b0;

    function automatic ring_outcome_t step_ring(ring_req_t rq);
        ring_outcome_t o;
        logic [6:0] nxt;
        logic [mdr_pkg::OFS_OUT_W-1:0] ofs;
        o.status = mdr_pkg::STAT_OK;
        o.assigned = '0;
        nxt = tail_idx + 7'd1;
        if (rq.op == mdr_pkg::OP_ENQUEUE)
        begin
            if (nxt == head_idx)
            begin
                o.status = mdr_pkg::STAT_FULL;
            end
            else if (rq.msg_len > buf_bytes)
            begin
                o.status = mdr_pkg::STAT_TOO_BIG;
            end
            else
            begin
                ofs = alloc_ptr;
                if ({1'b0, ofs} + {1'b0, rq.msg_len} > {1'b0, buf_bytes})
                    ofs = '0;
                slots[tail_idx] = '{rq.msg_len, rq.msg_kind, ofs};
                alloc_ptr = ofs + rq.msg_len;
                tail_idx = nxt;
                o.assigned = ofs;
            end
        end
        else if (head_idx == tail_idx)
        begin
            o.status = mdr_pkg::STAT_EMPTY;
        end
        else
        begin
            head_idx = head_idx + 7'd1;
        end
        nxt = tail_idx + 7'd1;
        o.empty = (head_idx == tail_idx);
        o.full = (nxt == head_idx);
        if (o.empty)
        begin
            o.f_len = '0;
            o.f_kind = '0;
            o.f_ofs = '0;
        end
        else
        begin
            o.f_len = slots[head_idx].msg_len;
            o.f_kind = slots[head_idx].msg_kind;
            o.f_ofs = slots[head_idx].msg_ofs;
        end
        return o;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(step_ring(cur_req));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    cur_req = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.msg_kind, cur_req.msg_len};
                    s_tuser <= cur_req.op;
                    if (!calm && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 18);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        ring_outcome_t w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    $error("result item with no expectation waiting");
                end
                else
                begin
                    w = outcome_q.pop_front();
                    check_field("status", w.status, m_tdata[1:0]);
                    check_field("assigned_offset", w.assigned, m_tdata[17:2]);
                    check_field("is_empty", w.empty, m_tdata[18]);
                    check_field("is_full", w.full, m_tdata[19]);
                    check_field("front_size", w.f_len, m_tdata[35:20]);
                    check_field("front_type", w.f_kind, m_tdata[43:36]);
                    check_field("front_offset", w.f_ofs, m_tdata[59:44]);
                end
            end
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 18);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic add_req(input mdr_pkg::op_t op, input logic [15:0] len,
                           input logic [7:0] kind);
        ring_req_t rq;
        rq.op = op;
        rq.msg_len = len;
        rq.msg_kind = kind;
        pend_q.push_back(rq);
    endtask

    task automatic add_enqueue();
        int pick;
        logic [15:0] len;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            len = 16'($urandom_range(0, buf_bytes));
        else if (pick == 6)
            len = buf_bytes;
        else if (pick == 7)
            len = (buf_bytes == 16'hFFFF) ? buf_bytes : buf_bytes + 16'd1;
        else if (pick == 8)
            len = 16'($urandom_range(0, 65535));
        else
            len = '0;
        add_req(mdr_pkg::OP_ENQUEUE, len, 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_phase(input int n);
        int done;
        int pick;
        int run;
        int pop_pct;
        done = 0;
        while (done < n)
        begin
            pick = $urandom_range(0, 5);
            case (pick)
                0:
                begin
                    run = 190;
                    pop_pct = 0;
                end
                1:
                begin
                    run = 150;
                    pop_pct = 100;
                end
                2:
                begin
                    run = $urandom_range(5, 40);
                    pop_pct = 30;
                end
                3:
                begin
                    run = $urandom_range(5, 40);
                    pop_pct = 50;
                end
                4:
                begin
                    run = $urandom_range(5, 40);
                    pop_pct = 70;
                end
                default:
                begin
                    run = $urandom_range(5, 40);
                    pop_pct = 40;
                end
            endcase
            for (int k = 0; k < run && done < n; k++)
            begin
                if ($urandom_range(0, 99) < pop_pct)
                    add_req(mdr_pkg::OP_POP, 16'($urandom_range(0, 65535)),
                            8'($urandom_range(0, 255)));
                else
                    add_enqueue();
                done++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_buffer_size(input logic [15:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        buf_bytes = v;
    endtask

    initial
    begin
        int settings [7];
        settings = '{1, 65535, 300, -1, 4096, -1, 65535};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_req(mdr_pkg::OP_POP, 16'h0000, 8'h00);
        add_req(mdr_pkg::OP_ENQUEUE, 16'h0000, 8'h00);
        add_req(mdr_pkg::OP_ENQUEUE, 16'hFFFF, 8'hFF);
        add_req(mdr_pkg::OP_ENQUEUE, 16'h0001, 8'h5A);
        add_req(mdr_pkg::OP_ENQUEUE, 16'hAAAA, 8'hAA);
        add_req(mdr_pkg::OP_POP, 16'hFFFF, 8'hFF);
        add_req(mdr_pkg::OP_POP, 16'h5555, 8'h55);
        add_req(mdr_pkg::OP_POP, 16'h0000, 8'h00);
        add_req(mdr_pkg::OP_POP, 16'h0000, 8'h00);
        add_req(mdr_pkg::OP_POP, 16'h0000, 8'h00);
        wait_idle();

        write_buffer_size(16'd100);
        add_req(mdr_pkg::OP_ENQUEUE, 16'd101, 8'h11);
        add_req(mdr_pkg::OP_ENQUEUE, 16'd100, 8'h22);
        add_req(mdr_pkg::OP_ENQUEUE, 16'd0, 8'h33);
        add_req(mdr_pkg::OP_ENQUEUE, 16'd1, 8'h44);
        add_req(mdr_pkg::OP_ENQUEUE, 16'hFFFF, 8'h55);
        add_req(mdr_pkg::OP_POP, 16'd0, 8'h00);
        add_req(mdr_pkg::OP_POP, 16'd0, 8'h00);
        add_req(mdr_pkg::OP_POP, 16'd0, 8'h00);
        wait_idle();

        write_buffer_size(16'd0);
        add_req(mdr_pkg::OP_ENQUEUE, 16'd0, 8'h66);
        add_req(mdr_pkg::OP_ENQUEUE, 16'd1, 8'h77);
        add_req(mdr_pkg::OP_POP, 16'd0, 8'h00);
        add_req(mdr_pkg::OP_POP, 16'd0, 8'h00);
        wait_idle();

        for (int i = 0; i < 7; i++)
        begin
            if (settings[i] < 0)
                write_buffer_size(16'($urandom_range(1, 65535)));
            else
                write_buffer_size(16'(settings[i]));
            if (i == 6)
                calm = 1'b1;
            queue_phase(PHASE_ITEMS);
            if (i == 2)
                hold_ask++;
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
